>>> design/scbp_pkg.sv
package scbp_pkg;

    localparam int MAX_BLOCKS    = 32;
    localparam int BLOCK_W       = 5;
    localparam int CLASS_W       = 3;
    localparam int PTR_W         = 6;
    localparam int SIZE_W        = 16;
    localparam int FIELD_W       = 9;
    localparam int REFS_W        = 8;
    localparam int MIN_PER_CLASS = 2;

    localparam int NUM_CLASSES_DEF = 4;
    localparam int MIN_SIZE_DEF    = 64;
    localparam int BASE_COUNT_DEF  = 16;

    typedef enum logic [2:0] {
        REQ_ALLOC     = 3'd0,
        REQ_ADD_REF   = 3'd1,
        REQ_RELEASE   = 3'd2,
        REQ_SET_VALID = 3'd3,
        REQ_MOVE_RD   = 3'd4,
        REQ_MOVE_WR   = 3'd5,
        REQ_INSPECT   = 3'd6
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_TOO_LARGE  = 2'd1,
        ST_NO_FREE    = 2'd2,
        ST_NOT_IN_USE = 2'd3
    } status_t;

    typedef struct packed {
        req_type_t            kind;
        logic [BLOCK_W-1:0]   id;
        logic [FIELD_W-1:0]   nbytes;
        logic                 alloc_wr;
        logic [BLOCK_W-1:0]   alloc_id;
        logic [FIELD_W-1:0]   alloc_size;
    } bt_req_t;

    typedef struct packed {
        status_t              status;
        logic [FIELD_W-1:0]   capacity;
        logic [FIELD_W-1:0]   used_size;
        logic                 is_valid;
        logic [REFS_W-1:0]    ref_count;
        logic [FIELD_W-1:0]   moved;
    } bt_rsp_t;

    typedef struct packed {
        logic                 valid;
        logic [CLASS_W-1:0]   cls;
        logic [BLOCK_W-1:0]   id;
    } fl_push_t;

    typedef struct packed {
        logic                 pop;
        logic [CLASS_W-1:0]   min_class;
    } fl_pop_t;

    function automatic int cls_base(int c, int base_count);
        int next;
        int n;
        next = 0;
        for (int k = 0; k < c; k++)
        begin
            n = base_count >> k;
            if (n < MIN_PER_CLASS)
            begin
                n = MIN_PER_CLASS;
            end
            if (n > MAX_BLOCKS - next)
            begin
                n = MAX_BLOCKS - next;
            end
            next = next + n;
        end
        return next;
    endfunction

    function automatic int cls_count(int c, int base_count);
        return cls_base(c + 1, base_count) - cls_base(c, base_count);
    endfunction

    function automatic int total_blocks(int num_classes, int base_count);
        return cls_base(num_classes, base_count);
    endfunction

    function automatic int block_cls(int id, int num_classes, int base_count);
        int cls;
        cls = 0;
        for (int k = 0; k < num_classes; k++)
        begin
            if (id >= cls_base(k, base_count))
            begin
                cls = k;
            end
        end
        return cls;
    endfunction

endpackage

>>> design/scbp_free_list.sv
module scbp_free_list #(
    parameter int NUM_CLASSES = scbp_pkg::NUM_CLASSES_DEF,
    parameter int BASE_COUNT  = scbp_pkg::BASE_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  scbp_pkg::fl_pop_t               pop_req,
    input  scbp_pkg::fl_push_t              push,
    output logic                            found,
    output logic [scbp_pkg::CLASS_W-1:0]    pop_class,
    output logic [scbp_pkg::BLOCK_W-1:0]    pop_id
);

    logic [scbp_pkg::BLOCK_W-1:0] free_stack_reg [scbp_pkg::MAX_BLOCKS];
    logic [scbp_pkg::PTR_W-1:0]   stack_top_reg [NUM_CLASSES];
    logic [scbp_pkg::PTR_W-1:0]   base_tab [NUM_CLASSES];
    logic [scbp_pkg::PTR_W-1:0]   count_tab [NUM_CLASSES];

    logic [scbp_pkg::PTR_W-1:0]   sel_top;
    logic [scbp_pkg::PTR_W-1:0]   sel_base;
    logic [scbp_pkg::PTR_W-1:0]   push_top;
    logic [scbp_pkg::PTR_W-1:0]   push_base;
    logic [scbp_pkg::PTR_W-1:0]   push_count;
    logic [scbp_pkg::PTR_W-1:0]   pop_ptr;
    logic [scbp_pkg::PTR_W-1:0]   push_ptr;
    logic                         do_pop;
    logic                         do_push;

    for (genvar g = 0; g < NUM_CLASSES; g++)
    begin : g_class_tab
        assign base_tab[g]  = scbp_pkg::PTR_W'(scbp_pkg::cls_base(g, BASE_COUNT));
        assign count_tab[g] = scbp_pkg::PTR_W'(scbp_pkg::cls_count(g, BASE_COUNT));
    end

    // The lowest non-empty class at or above the requested one wins.
    always_comb
    begin
        found     = 1'b0;
        pop_class = '0;
        for (int k = NUM_CLASSES - 1; k >= 0; k--)
        begin
            if ((scbp_pkg::CLASS_W'(k) >= pop_req.min_class) && (stack_top_reg[k] != '0))
            begin
                found     = 1'b1;
                pop_class = scbp_pkg::CLASS_W'(k);
            end
        end
    end

    always_comb
    begin
        sel_top    = '0;
        sel_base   = '0;
        push_top   = '0;
        push_base  = '0;
        push_count = '0;
        for (int k = 0; k < NUM_CLASSES; k++)
        begin
            if (pop_class == scbp_pkg::CLASS_W'(k))
            begin
                sel_top  = stack_top_reg[k];
                sel_base = base_tab[k];
            end
            if (push.cls == scbp_pkg::CLASS_W'(k))
            begin
                push_top   = stack_top_reg[k];
                push_base  = base_tab[k];
                push_count = count_tab[k];
            end
        end
    end

    assign pop_ptr  = sel_base + sel_top - scbp_pkg::PTR_W'(1);
    assign push_ptr = push_base + push_top;
    assign pop_id   = free_stack_reg[pop_ptr[scbp_pkg::BLOCK_W-1:0]];
    assign do_pop   = pop_req.pop && found;
    assign do_push  = advance && push.valid && (push_top < push_count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < scbp_pkg::MAX_BLOCKS; i++)
            begin
                free_stack_reg[i] <= scbp_pkg::BLOCK_W'(i);
            end
            for (int k = 0; k < NUM_CLASSES; k++)
            begin
                stack_top_reg[k] <= count_tab[k];
            end
        end
        else
        begin
            if (do_push)
            begin
                free_stack_reg[push_ptr[scbp_pkg::BLOCK_W-1:0]] <= push.id;
            end
            for (int k = 0; k < NUM_CLASSES; k++)
            begin
                if (do_pop && (pop_class == scbp_pkg::CLASS_W'(k)))
                begin
                    stack_top_reg[k] <= stack_top_reg[k] - scbp_pkg::PTR_W'(1);
                end
                else if (do_push && (push.cls == scbp_pkg::CLASS_W'(k)))
                begin
                    stack_top_reg[k] <= stack_top_reg[k] + scbp_pkg::PTR_W'(1);
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_pop_push_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop_req.pop && advance && push.valid))
        else $error("free list asked to pop and push in one cycle");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop |-> (sel_top != '0) && (pop_class >= pop_req.min_class))
        else $error("pop from an empty or too small class");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        do_push |=> free_stack_reg[$past(push_ptr[scbp_pkg::BLOCK_W-1:0])] == $past(push.id))
        else $error("pushed block id not stored");
`endif

endmodule

>>> design/scbp_block_table.sv
module scbp_block_table #(
    parameter int NUM_CLASSES = scbp_pkg::NUM_CLASSES_DEF,
    parameter int MIN_SIZE    = scbp_pkg::MIN_SIZE_DEF,
    parameter int BASE_COUNT  = scbp_pkg::BASE_COUNT_DEF,
    parameter int CAP_W       = $clog2(MIN_SIZE * NUM_CLASSES + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  scbp_pkg::bt_req_t   req,
    output scbp_pkg::bt_rsp_t   rsp,
    output scbp_pkg::fl_push_t  push
);

    localparam int TOTAL = scbp_pkg::total_blocks(NUM_CLASSES, BASE_COUNT);
    localparam int MOV_W = (CAP_W > scbp_pkg::FIELD_W) ? CAP_W : scbp_pkg::FIELD_W;

    logic [scbp_pkg::REFS_W-1:0]  refs_reg  [scbp_pkg::MAX_BLOCKS];
    logic [scbp_pkg::FIELD_W-1:0] size_reg  [scbp_pkg::MAX_BLOCKS];
    logic                         valid_reg [scbp_pkg::MAX_BLOCKS];
    logic [CAP_W-1:0]             rd_reg    [scbp_pkg::MAX_BLOCKS];
    logic [CAP_W-1:0]             wr_reg    [scbp_pkg::MAX_BLOCKS];

    logic [CAP_W-1:0]             cap_tab     [scbp_pkg::MAX_BLOCKS];
    logic [scbp_pkg::CLASS_W-1:0] cls_tab     [scbp_pkg::MAX_BLOCKS];
    logic                         present_tab [scbp_pkg::MAX_BLOCKS];

    logic [scbp_pkg::REFS_W-1:0]  refs_cur;
    logic [scbp_pkg::FIELD_W-1:0] size_cur;
    logic                         valid_cur;
    logic [CAP_W-1:0]             rd_cur;
    logic [CAP_W-1:0]             wr_cur;
    logic [CAP_W-1:0]             cap_cur;
    logic                         in_use;
    logic                         write_en;

    logic [scbp_pkg::REFS_W-1:0]  refs_next;
    logic [scbp_pkg::FIELD_W-1:0] size_next;
    logic                         valid_next;
    logic [CAP_W-1:0]             rd_next;
    logic [CAP_W-1:0]             wr_next;
    logic [CAP_W-1:0]             avail_len;
    logic [CAP_W-1:0]             avail_space;
    logic [MOV_W-1:0]             limit;
    logic [MOV_W-1:0]             moved_w;

    for (genvar g = 0; g < scbp_pkg::MAX_BLOCKS; g++)
    begin : g_block_tab
        localparam int CLS = scbp_pkg::block_cls(g, NUM_CLASSES, BASE_COUNT);
        assign cap_tab[g]     = (g < TOTAL) ? CAP_W'(MIN_SIZE * (CLS + 1)) : '0;
        assign cls_tab[g]     = scbp_pkg::CLASS_W'(CLS);
        assign present_tab[g] = (g < TOTAL);
    end

    assign refs_cur  = refs_reg[req.id];
    assign size_cur  = size_reg[req.id];
    assign valid_cur = valid_reg[req.id];
    assign rd_cur    = rd_reg[req.id];
    assign wr_cur    = wr_reg[req.id];
    assign cap_cur   = cap_tab[req.id];
    assign in_use    = present_tab[req.id] && (refs_cur != '0);
    assign write_en  = advance && (req.kind != scbp_pkg::REQ_ALLOC) && in_use;

    assign avail_len   = (wr_cur > rd_cur) ? (wr_cur - rd_cur) : '0;
    assign avail_space = (cap_cur > wr_cur) ? (cap_cur - wr_cur) : '0;

    always_comb
    begin
        refs_next  = refs_cur;
        size_next  = size_cur;
        valid_next = valid_cur;
        rd_next    = rd_cur;
        wr_next    = wr_cur;
        limit      = '0;
        moved_w    = '0;
        push       = '0;
        case (req.kind)
            scbp_pkg::REQ_ADD_REF:
            begin
                if (refs_cur != '1)
                begin
                    refs_next = refs_cur + scbp_pkg::REFS_W'(1);
                end
            end
            scbp_pkg::REQ_RELEASE:
            begin
                refs_next = refs_cur - scbp_pkg::REFS_W'(1);
                if (refs_cur == scbp_pkg::REFS_W'(1))
                begin
                    size_next  = '0;
                    valid_next = 1'b0;
                    push.valid = in_use;
                    push.cls   = cls_tab[req.id];
                    push.id    = req.id;
                end
            end
            scbp_pkg::REQ_SET_VALID:
            begin
                valid_next = 1'b1;
            end
            scbp_pkg::REQ_MOVE_RD:
            begin
                limit   = MOV_W'(avail_len);
                moved_w = (MOV_W'(req.nbytes) < limit) ? MOV_W'(req.nbytes) : limit;
                rd_next = rd_cur + CAP_W'(moved_w);
            end
            scbp_pkg::REQ_MOVE_WR:
            begin
                limit   = MOV_W'(avail_space);
                moved_w = (MOV_W'(req.nbytes) < limit) ? MOV_W'(req.nbytes) : limit;
                wr_next = wr_cur + CAP_W'(moved_w);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rsp          = '0;
        rsp.capacity = scbp_pkg::FIELD_W'(cap_cur);
        if (!in_use)
        begin
            rsp.status = scbp_pkg::ST_NOT_IN_USE;
        end
        else
        begin
            rsp.status    = scbp_pkg::ST_OK;
            rsp.used_size = size_next;
            rsp.is_valid  = valid_next;
            rsp.ref_count = refs_next;
            rsp.moved     = scbp_pkg::FIELD_W'(moved_w);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < scbp_pkg::MAX_BLOCKS; i++)
            begin
                refs_reg[i] <= '0;
            end
        end
        else if (req.alloc_wr)
        begin
            refs_reg[req.alloc_id] <= scbp_pkg::REFS_W'(1);
        end
        else if (write_en)
        begin
            refs_reg[req.id] <= refs_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.alloc_wr)
        begin
            size_reg[req.alloc_id]  <= req.alloc_size;
            valid_reg[req.alloc_id] <= 1'b0;
            rd_reg[req.alloc_id]    <= '0;
            wr_reg[req.alloc_id]    <= '0;
        end
        else if (write_en)
        begin
            size_reg[req.id]  <= size_next;
            valid_reg[req.id] <= valid_next;
            rd_reg[req.id]    <= rd_next;
            wr_reg[req.id]    <= wr_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_release_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (write_en && push.valid) |=> refs_reg[$past(req.id)] == '0)
        else $error("released block still holds references");

    a_alloc_one_ref: assert property (@(posedge clk) disable iff (!rst_n)
        req.alloc_wr |=> refs_reg[$past(req.alloc_id)] == scbp_pkg::REFS_W'(1))
        else $error("allocated block does not hold one reference");

    a_alloc_was_free: assert property (@(posedge clk) disable iff (!rst_n)
        req.alloc_wr |-> refs_reg[req.alloc_id] == '0)
        else $error("allocation handed out a block in use");
`endif

endmodule

>>> design/size_class_block_pool.sv
// Channel  Direction  Payload (lowest bit first)
// s_axis   in         tuser: req_type; tdata: req_size, block_id, byte_count
// m_axis   out        tuser: status; tdata: result_block, capacity, used_size,
//                     is_valid, ref_count, moved
//
// Every request passes through the input register, then the result register, on its
// way to its result. A new request can be taken every cycle unless the result stalls.
// The block-state table and the free stacks are updated as a request moves into
// the result register, so the next request already sees the change.
// Reset fills every class free stack and marks all blocks free; no clearing pass.
// A stalled result holds the request in the input register; both sides stall then.
module size_class_block_pool #(
    parameter int NUM_CLASSES = scbp_pkg::NUM_CLASSES_DEF,
    parameter int MIN_SIZE    = scbp_pkg::MIN_SIZE_DEF,
    parameter int BASE_COUNT  = scbp_pkg::BASE_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // req_size, block_id, byte_count
    input  logic [2:0]  s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // result_block, capacity, used_size,
                                        // is_valid, ref_count, moved
    output logic [1:0]  m_axis_tuser    // status
);

    localparam int CAP_W = $clog2(MIN_SIZE * NUM_CLASSES + 1);

    logic                             in_valid_reg;
    scbp_pkg::req_type_t              in_type_reg;
    logic [scbp_pkg::SIZE_W-1:0]      in_size_reg;
    logic [scbp_pkg::BLOCK_W-1:0]     in_id_reg;
    logic [scbp_pkg::FIELD_W-1:0]     in_nbytes_reg;

    logic                             out_valid_reg;
    scbp_pkg::status_t                out_status_reg;
    logic [scbp_pkg::BLOCK_W-1:0]     out_block_reg;
    logic [scbp_pkg::FIELD_W-1:0]     out_cap_reg;
    logic [scbp_pkg::FIELD_W-1:0]     out_used_reg;
    logic                             out_is_valid_reg;
    logic [scbp_pkg::REFS_W-1:0]      out_refs_reg;
    logic [scbp_pkg::FIELD_W-1:0]     out_moved_reg;

    scbp_pkg::status_t                out_status_next;
    logic [scbp_pkg::BLOCK_W-1:0]     out_block_next;
    logic [scbp_pkg::FIELD_W-1:0]     out_cap_next;
    logic [scbp_pkg::FIELD_W-1:0]     out_used_next;
    logic                             out_is_valid_next;
    logic [scbp_pkg::REFS_W-1:0]      out_refs_next;
    logic [scbp_pkg::FIELD_W-1:0]     out_moved_next;

    logic                             advance;
    logic                             is_alloc;
    logic                             too_large;
    logic [scbp_pkg::CLASS_W-1:0]     size_cls;
    logic                             found;
    logic [scbp_pkg::CLASS_W-1:0]     pop_class;
    logic [scbp_pkg::BLOCK_W-1:0]     pop_id;
    logic [CAP_W-1:0]                 alloc_cap;
    scbp_pkg::fl_pop_t                pop_req;
    scbp_pkg::fl_push_t               push;
    scbp_pkg::bt_req_t                bt_req;
    scbp_pkg::bt_rsp_t                bt_rsp;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign is_alloc      = (in_type_reg == scbp_pkg::REQ_ALLOC);

    assign too_large = {16'd0, in_size_reg} > 32'(MIN_SIZE * NUM_CLASSES);

    always_comb
    begin
        size_cls = '0;
        for (int k = 0; k < NUM_CLASSES; k++)
        begin
            if ({16'd0, in_size_reg} > 32'(MIN_SIZE * (k + 1)))
            begin
                size_cls = size_cls + scbp_pkg::CLASS_W'(1);
            end
        end
    end

    assign pop_req.pop       = advance && is_alloc && !too_large;
    assign pop_req.min_class = size_cls;

    scbp_free_list #(
        .NUM_CLASSES (NUM_CLASSES),
        .BASE_COUNT  (BASE_COUNT)
    ) u_free_list (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .pop_req   (pop_req),
        .push      (push),
        .found     (found),
        .pop_class (pop_class),
        .pop_id    (pop_id)
    );

    assign bt_req.kind       = in_type_reg;
    assign bt_req.id         = in_id_reg;
    assign bt_req.nbytes     = in_nbytes_reg;
    assign bt_req.alloc_wr   = pop_req.pop && found;
    assign bt_req.alloc_id   = pop_id;
    assign bt_req.alloc_size = in_size_reg[scbp_pkg::FIELD_W-1:0];

    scbp_block_table #(
        .NUM_CLASSES (NUM_CLASSES),
        .MIN_SIZE    (MIN_SIZE),
        .BASE_COUNT  (BASE_COUNT),
        .CAP_W       (CAP_W)
    ) u_block_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .req     (bt_req),
        .rsp     (bt_rsp),
        .push    (push)
    );

    assign alloc_cap = CAP_W'(MIN_SIZE) * (CAP_W'(pop_class) + CAP_W'(1));

    always_comb
    begin
        out_status_next   = bt_rsp.status;
        out_block_next    = in_id_reg;
        out_cap_next      = bt_rsp.capacity;
        out_used_next     = bt_rsp.used_size;
        out_is_valid_next = bt_rsp.is_valid;
        out_refs_next     = bt_rsp.ref_count;
        out_moved_next    = bt_rsp.moved;
        if (is_alloc)
        begin
            out_block_next    = '0;
            out_cap_next      = '0;
            out_used_next     = '0;
            out_is_valid_next = 1'b0;
            out_refs_next     = '0;
            out_moved_next    = '0;
            if (too_large)
            begin
                out_status_next = scbp_pkg::ST_TOO_LARGE;
            end
            else if (!found)
            begin
                out_status_next = scbp_pkg::ST_NO_FREE;
            end
            else
            begin
                out_status_next = scbp_pkg::ST_OK;
                out_block_next  = pop_id;
                out_cap_next    = scbp_pkg::FIELD_W'(alloc_cap);
                out_used_next   = in_size_reg[scbp_pkg::FIELD_W-1:0];
                out_refs_next   = scbp_pkg::REFS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_type_reg   <= scbp_pkg::req_type_t'(s_axis_tuser);
            in_size_reg   <= s_axis_tdata[15:0];
            in_id_reg     <= s_axis_tdata[20:16];
            in_nbytes_reg <= s_axis_tdata[29:21];
        end
        if (advance)
        begin
            out_status_reg   <= out_status_next;
            out_block_reg    <= out_block_next;
            out_cap_reg      <= out_cap_next;
            out_used_reg     <= out_used_next;
            out_is_valid_reg <= out_is_valid_next;
            out_refs_reg     <= out_refs_next;
            out_moved_reg    <= out_moved_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {7'd0, out_moved_reg, out_refs_reg, out_is_valid_reg,
                            out_used_reg, out_cap_reg, out_block_reg};

`ifndef NO_ASSERTIONS
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled while the result register is empty");

    a_advance_shows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_axis_tvalid)
        else $error("processed request produced no result");

    a_too_large: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_alloc && too_large) |=>
            (m_axis_tuser == scbp_pkg::ST_TOO_LARGE) && (m_axis_tdata == '0))
        else $error("oversized allocation not reported");
`endif

endmodule

>>> tb/size_class_block_pool_monitor.sv
`timescale 1ns / 1ps

module size_class_block_pool_monitor #(
    parameter int NUM_CLASSES = scbp_pkg::NUM_CLASSES_DEF,
    parameter int MIN_SIZE    = scbp_pkg::MIN_SIZE_DEF,
    parameter int BASE_COUNT  = scbp_pkg::BASE_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // req_size, block_id, byte_count
    input  logic [2:0]  s_axis_tuser,   // req_type
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,   // result_block, capacity, used_size,
                                        // is_valid, ref_count, moved
    input  logic [1:0]  m_axis_tuser,   // status
    output int          mismatches,
    output int          pending
);

    typedef struct packed {
        scbp_pkg::status_t            status;
        logic [scbp_pkg::BLOCK_W-1:0] blk;
        logic [scbp_pkg::FIELD_W-1:0] cap;
        logic [scbp_pkg::FIELD_W-1:0] used;
        logic                         valid;
        logic [scbp_pkg::REFS_W-1:0]  refs;
        logic [scbp_pkg::FIELD_W-1:0] moved;
    } pool_rsp_t;

    logic [scbp_pkg::BLOCK_W-1:0] free_ids   [scbp_pkg::MAX_BLOCKS];
    int                           free_top   [NUM_CLASSES];
    int                           cls_first  [NUM_CLASSES];
    int                           cls_quota  [NUM_CLASSES];
    int                           owner_cls  [scbp_pkg::MAX_BLOCKS];
    int                           n_blocks;
    logic [scbp_pkg::SIZE_W-1:0]  held_size  [scbp_pkg::MAX_BLOCKS];
    logic                         held_valid [scbp_pkg::MAX_BLOCKS];
    logic [scbp_pkg::REFS_W-1:0]  held_refs  [scbp_pkg::MAX_BLOCKS];
    int                           rd_off     [scbp_pkg::MAX_BLOCKS];
    int                           wr_off     [scbp_pkg::MAX_BLOCKS];
    pool_rsp_t                    rsp_due    [$];
    int                           err_n = 0;

    task automatic fill_pool();
        int next;
        int n;
        next = 0;
        for (int b = 0; b < scbp_pkg::MAX_BLOCKS; b++)
        begin
            free_ids[b]   = '0;
            owner_cls[b]  = 0;
            held_size[b]  = '0;
            held_valid[b] = 1'b0;
            held_refs[b]  = '0;
            rd_off[b]     = 0;
            wr_off[b]     = 0;
        end
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            n = BASE_COUNT >> c;
            if (n < scbp_pkg::MIN_PER_CLASS)
                n = scbp_pkg::MIN_PER_CLASS;
            if (n > scbp_pkg::MAX_BLOCKS - next)
                n = scbp_pkg::MAX_BLOCKS - next;
            cls_first[c] = next;
            cls_quota[c] = n;
            free_top[c]  = n;
            for (int j = 0; j < n; j++)
            begin
                free_ids[next + j]  = scbp_pkg::BLOCK_W'(next + j);
                owner_cls[next + j] = c;
            end
            next = next + n;
        end
        n_blocks = next;
        rsp_due.delete();
    endtask

    function automatic pool_rsp_t serve_request(logic [2:0] kind,
                                                logic [scbp_pkg::SIZE_W-1:0] size,
                                                logic [scbp_pkg::BLOCK_W-1:0] id,
                                                logic [scbp_pkg::FIELD_W-1:0] nbytes);
        pool_rsp_t                    rsp;
        int                           cls;
        int                           cap;
        int                           span;
        logic [scbp_pkg::BLOCK_W-1:0] b;
        rsp = '0;
        if (kind == scbp_pkg::REQ_ALLOC)
        begin
            cls = (size == 0) ? 0 : (int'(size) - 1) / MIN_SIZE;
            if (cls >= NUM_CLASSES)
            begin
                rsp.status = scbp_pkg::ST_TOO_LARGE;
                return rsp;
            end
            while (cls < NUM_CLASSES && free_top[cls] == 0)
                cls++;
            if (cls >= NUM_CLASSES)
            begin
                rsp.status = scbp_pkg::ST_NO_FREE;
                return rsp;
            end
            free_top[cls]--;
            b = free_ids[(cls_first[cls] + free_top[cls]) % scbp_pkg::MAX_BLOCKS];
            held_size[b]  = size;
            held_valid[b] = 1'b0;
            held_refs[b]  = scbp_pkg::REFS_W'(1);
            rd_off[b]     = 0;
            wr_off[b]     = 0;
            rsp.status = scbp_pkg::ST_OK;
            rsp.blk    = b;
            rsp.cap    = scbp_pkg::FIELD_W'(MIN_SIZE * (cls + 1));
            rsp.used   = size[scbp_pkg::FIELD_W-1:0];
            rsp.refs   = scbp_pkg::REFS_W'(1);
            return rsp;
        end

        cap = (id < n_blocks) ? MIN_SIZE * (owner_cls[id] + 1) : 0;
        rsp.blk = id;
        rsp.cap = scbp_pkg::FIELD_W'(cap);
        if (id >= n_blocks || held_refs[id] == 0)
        begin
            rsp.status = scbp_pkg::ST_NOT_IN_USE;
            return rsp;
        end

        span = 0;
        case (kind)
            scbp_pkg::REQ_ADD_REF:
            begin
                if (held_refs[id] != '1)
                    held_refs[id]++;
            end
            scbp_pkg::REQ_RELEASE:
            begin
                held_refs[id]--;
                if (held_refs[id] == 0)
                begin
                    cls = owner_cls[id];
                    held_size[id]  = '0;
                    held_valid[id] = 1'b0;
                    if (free_top[cls] < cls_quota[cls])
                    begin
                        free_ids[(cls_first[cls] + free_top[cls]) % scbp_pkg::MAX_BLOCKS] = id;
                        free_top[cls]++;
                    end
                end
            end
            scbp_pkg::REQ_SET_VALID:
            begin
                held_valid[id] = 1'b1;
            end
            scbp_pkg::REQ_MOVE_RD:
            begin
                span = (wr_off[id] > rd_off[id]) ? wr_off[id] - rd_off[id] : 0;
                if (int'(nbytes) < span)
                    span = int'(nbytes);
                rd_off[id] += span;
            end
            scbp_pkg::REQ_MOVE_WR:
            begin
                span = (cap > wr_off[id]) ? cap - wr_off[id] : 0;
                if (int'(nbytes) < span)
                    span = int'(nbytes);
                wr_off[id] += span;
            end
            default:
            begin
            end
        endcase
        rsp.status = scbp_pkg::ST_OK;
        rsp.used   = held_size[id][scbp_pkg::FIELD_W-1:0];
        rsp.valid  = held_valid[id];
        rsp.refs   = held_refs[id];
        rsp.moved  = scbp_pkg::FIELD_W'(span);
        return rsp;
    endfunction

    task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_n++;
        end
    endtask

    task automatic check_result(logic [1:0] st, logic [47:0] bits);
        pool_rsp_t want;
        if (rsp_due.size() == 0)
        begin
            $error("response transfer with no request outstanding: status %0d block %0d",
                   st, bits[4:0]);
            err_n++;
            return;
        end
        want = rsp_due.pop_front();
        compare_field("status", 16'(want.status), 16'(st));
        compare_field("result_block", 16'(want.blk), 16'(bits[4:0]));
        compare_field("capacity", 16'(want.cap), 16'(bits[13:5]));
        compare_field("used_size", 16'(want.used), 16'(bits[22:14]));
        compare_field("is_valid", 16'(want.valid), 16'(bits[23]));
        compare_field("ref_count", 16'(want.refs), 16'(bits[31:24]));
        compare_field("moved", 16'(want.moved), 16'(bits[40:32]));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_pool();
            pending    <= 0;
            mismatches <= err_n;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tuser, m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                rsp_due.push_back(serve_request(s_axis_tuser, s_axis_tdata[15:0],
                                                s_axis_tdata[20:16], s_axis_tdata[29:21]));
            pending    <= rsp_due.size();
            mismatches <= err_n;
        end
    end

endmodule

>>> tb/size_class_block_pool_tb.sv
`timescale 1ns / 1ps

module size_class_block_pool_tb;

    localparam logic [2:0] REQ_UNKNOWN = 3'd7;
    localparam int         STALL_PCT   = 19;
    localparam int         QUIET_LIMIT = 2000;
    localparam int         CHUNK       = 100;
    localparam int         CHUNKS      = 7;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;     // req_size, block_id, byte_count
    logic [2:0]  s_axis_tuser = '0;     // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;          // result_block, capacity, used_size,
                                        // is_valid, ref_count, moved
    logic [1:0]  m_axis_tuser;          // status

    int                           mismatches;
    int                           pending;
    bit                           calm = 1'b0;
    bit                           live [scbp_pkg::MAX_BLOCKS];
    logic [2:0]                   kinds_sent [$];
    logic [scbp_pkg::BLOCK_W-1:0] granted [$];
    logic [2:0]                   done_kind;
    int                           quiet_cycles = 0;
    int                           n_sent = 0;
    int                           n_by_kind [8] = '{default: 0};
    int                           n_by_status [4] = '{default: 0};

    size_class_block_pool dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    size_class_block_pool_monitor pool_monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= rst_n && (calm || $urandom_range(99) >= STALL_PCT);
    end

    // Keeps a loose picture of which blocks are held so that most requests
    // name a block that is in use.
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready && kinds_sent.size() > 0)
        begin
            done_kind = kinds_sent.pop_front();
            n_by_status[m_axis_tuser]++;
            if (done_kind == scbp_pkg::REQ_ALLOC && m_axis_tuser == scbp_pkg::ST_OK)
            begin
                live[m_axis_tdata[4:0]] = 1'b1;
                granted.push_back(m_axis_tdata[4:0]);
            end
            else if (m_axis_tuser == scbp_pkg::ST_NOT_IN_USE)
                live[m_axis_tdata[4:0]] = 1'b0;
            else if (done_kind == scbp_pkg::REQ_RELEASE && m_axis_tdata[31:24] == 0)
                live[m_axis_tdata[4:0]] = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL size_class_block_pool");
            $finish;
        end
    end

    task automatic send_req(input logic [2:0] kind,
                            input logic [scbp_pkg::SIZE_W-1:0] size,
                            input logic [scbp_pkg::BLOCK_W-1:0] id,
                            input logic [scbp_pkg::FIELD_W-1:0] nbytes);
        while (!calm && $urandom_range(99) < STALL_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, nbytes, id, size};
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        kinds_sent.push_back(kind);
        n_sent++;
        n_by_kind[kind]++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        int                           pa;
        int                           pr;
        int                           r;
        int                           pick;
        logic [2:0]                   kind;
        logic [scbp_pkg::SIZE_W-1:0]  size;
        logic [scbp_pkg::BLOCK_W-1:0] id;
        logic [scbp_pkg::BLOCK_W-1:0] blk_a;
        logic [scbp_pkg::BLOCK_W-1:0] blk_b;
        logic [scbp_pkg::BLOCK_W-1:0] blk_c;
        logic [scbp_pkg::FIELD_W-1:0] nbytes;
        int                           held [$];

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Class boundaries, oversize requests and exhaustion of the top class.
        send_req(scbp_pkg::REQ_ALLOC, '0, '0, '0);
        send_req(scbp_pkg::REQ_ALLOC, scbp_pkg::SIZE_W'(scbp_pkg::MIN_SIZE_DEF), '0, '0);
        send_req(scbp_pkg::REQ_ALLOC, scbp_pkg::SIZE_W'(scbp_pkg::MIN_SIZE_DEF + 1), '0, '0);
        send_req(scbp_pkg::REQ_ALLOC, scbp_pkg::SIZE_W'(4 * scbp_pkg::MIN_SIZE_DEF), '0, '0);
        send_req(scbp_pkg::REQ_ALLOC, scbp_pkg::SIZE_W'(4 * scbp_pkg::MIN_SIZE_DEF + 1),
                 '0, '0);
        send_req(scbp_pkg::REQ_ALLOC, 16'hFFFF, '0, '0);
        send_req(scbp_pkg::REQ_ALLOC, scbp_pkg::SIZE_W'(4 * scbp_pkg::MIN_SIZE_DEF), '0, '0);
        send_req(scbp_pkg::REQ_ALLOC, scbp_pkg::SIZE_W'(3 * scbp_pkg::MIN_SIZE_DEF + 1),
                 '0, '0);
        wait_drained();
        blk_a = granted[0];
        blk_b = granted[1];
        blk_c = granted[3];

        send_req(scbp_pkg::REQ_MOVE_WR, '0, blk_a, scbp_pkg::FIELD_W'(256));
        send_req(scbp_pkg::REQ_MOVE_RD, '0, blk_a, scbp_pkg::FIELD_W'(10));
        send_req(scbp_pkg::REQ_MOVE_RD, '0, blk_a, scbp_pkg::FIELD_W'(256));
        send_req(scbp_pkg::REQ_MOVE_WR, '0, blk_a, '0);
        send_req(scbp_pkg::REQ_SET_VALID, '0, blk_a, '0);
        send_req(scbp_pkg::REQ_ADD_REF, '0, blk_a, '0);
        send_req(scbp_pkg::REQ_INSPECT, 16'hFFFF, blk_a, scbp_pkg::FIELD_W'(256));
        send_req(REQ_UNKNOWN, '0, blk_a, '0);
        send_req(scbp_pkg::REQ_RELEASE, '0, blk_a, '0);
        send_req(scbp_pkg::REQ_RELEASE, '0, blk_a, '0);
        send_req(scbp_pkg::REQ_RELEASE, '0, blk_a, '0);
        send_req(scbp_pkg::REQ_ADD_REF, '0, scbp_pkg::BLOCK_W'(scbp_pkg::MAX_BLOCKS - 2), '0);
        send_req(scbp_pkg::REQ_INSPECT, '0, scbp_pkg::BLOCK_W'(scbp_pkg::MAX_BLOCKS - 1), '0);
        send_req(scbp_pkg::REQ_MOVE_WR, '0, blk_c, scbp_pkg::FIELD_W'(256));
        send_req(scbp_pkg::REQ_MOVE_RD, '0, blk_c, scbp_pkg::FIELD_W'(256));

        // Drive one count into saturation and then all the way back to free.
        repeat (257) send_req(scbp_pkg::REQ_ADD_REF, '0, blk_b,
                              scbp_pkg::FIELD_W'($urandom_range(256)));
        repeat (257) send_req(scbp_pkg::REQ_RELEASE, '0, blk_b, '0);

        for (int chunk = 0; chunk < CHUNKS; chunk++)
        begin
            calm <= (chunk == 5);
            case (chunk % 3)
                0:
                begin
                    pa = 25;
                    pr = 20;
                end
                1:
                begin
                    pa = 55;
                    pr = 5;
                end
                default:
                begin
                    pa = 10;
                    pr = 45;
                end
            endcase
            for (int i = 0; i < CHUNK; i++)
            begin
                r = $urandom_range(99);
                if (r < pa)
                    kind = scbp_pkg::REQ_ALLOC;
                else if (r < pa + pr)
                    kind = scbp_pkg::REQ_RELEASE;
                else
                begin
                    case ($urandom_range(11))
                        0, 1:    kind = scbp_pkg::REQ_ADD_REF;
                        2, 3:    kind = scbp_pkg::REQ_SET_VALID;
                        4, 5, 6: kind = scbp_pkg::REQ_MOVE_RD;
                        7, 8, 9: kind = scbp_pkg::REQ_MOVE_WR;
                        10:      kind = scbp_pkg::REQ_INSPECT;
                        default: kind = REQ_UNKNOWN;
                    endcase
                end

                pick = $urandom_range(9);
                if (pick < 8)
                    size = scbp_pkg::SIZE_W'($urandom_range(256));
                else if (pick == 8)
                    size = scbp_pkg::SIZE_W'($urandom_range(65535));
                else
                    size = scbp_pkg::SIZE_W'(scbp_pkg::MIN_SIZE_DEF * $urandom_range(1, 4)
                                             + $urandom_range(1));

                held.delete();
                for (int b = 0; b < scbp_pkg::MAX_BLOCKS; b++)
                    if (live[b])
                        held.push_back(b);
                if (held.size() > 0 && $urandom_range(99) < 85)
                    id = scbp_pkg::BLOCK_W'(held[$urandom_range(held.size() - 1)]);
                else
                    id = scbp_pkg::BLOCK_W'($urandom_range(scbp_pkg::MAX_BLOCKS - 1));

                pick = $urandom_range(19);
                if (pick < 8)
                    nbytes = scbp_pkg::FIELD_W'($urandom_range(16));
                else if (pick < 17)
                    nbytes = scbp_pkg::FIELD_W'($urandom_range(256));
                else
                    nbytes = scbp_pkg::FIELD_W'(256);

                send_req(kind, size, id, nbytes);
            end
        end
        calm <= 1'b0;

        wait_drained();
        repeat (6) @(posedge clk);

        $display("Covered %0d requests: %0d alloc, %0d release, %0d add-ref, %0d move, %0d other.",
                 n_sent, n_by_kind[scbp_pkg::REQ_ALLOC], n_by_kind[scbp_pkg::REQ_RELEASE],
                 n_by_kind[scbp_pkg::REQ_ADD_REF],
                 n_by_kind[scbp_pkg::REQ_MOVE_RD] + n_by_kind[scbp_pkg::REQ_MOVE_WR],
                 n_by_kind[scbp_pkg::REQ_SET_VALID] + n_by_kind[scbp_pkg::REQ_INSPECT]
                 + n_by_kind[REQ_UNKNOWN]);
        $display("Responses: %0d ok, %0d too large, %0d no free block, %0d not in use.",
                 n_by_status[scbp_pkg::ST_OK], n_by_status[scbp_pkg::ST_TOO_LARGE],
                 n_by_status[scbp_pkg::ST_NO_FREE], n_by_status[scbp_pkg::ST_NOT_IN_USE]);
        if (mismatches == 0)
            $display("PASS size_class_block_pool");
        else
            $display("FAIL size_class_block_pool");
        $finish;
    end

endmodule

>>> sim.f
design/scbp_pkg.sv
design/scbp_free_list.sv
design/scbp_block_table.sv
design/size_class_block_pool.sv
tb/size_class_block_pool_monitor.sv
tb/size_class_block_pool_tb.sv
